// ----- rtl/imcf_pkg.sv -----
// ----------------------------------------------------------------------------
// imcf_pkg
// Shared constants, types and tables for the IMU motion cue filter.
// ----------------------------------------------------------------------------
package imcf_pkg;

  localparam int ACCEL_W = 16;
  localparam int SACC_W  = ACCEL_W + 8;
  localparam int ACC_MAX = (2 ** (ACCEL_W - 1)) - 1;
  localparam int ACC_MIN = -(2 ** (ACCEL_W - 1));

  localparam int CD_W    = 34;
  localparam int ANG_W   = 32;
  localparam int MA_W    = 34;
  localparam int MB_W    = 18;
  localparam int MACC_W  = 56;
  localparam int RED_W   = 33;

  localparam int CORDIC_ITERS = 20;
  localparam int ITER_W       = 5;

  localparam logic signed [ANG_W-1:0] PI_Q20      = 32'sd3294199;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q20  = 32'sd6588398;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q20 = 32'sd1647100;
  localparam logic signed [CD_W-1:0]  INV_GAIN_Q30 = 34'sd652032875;

  localparam logic signed [MB_W-1:0] INV_GAIN_Q16  = 18'sd39797;
  localparam logic signed [MB_W-1:0] LPF_W_Q16     = 18'sd19661;
  localparam logic signed [MB_W-1:0] GYRO_GAIN_Q16 = 18'sd74961;
  localparam logic signed [MB_W-1:0] COMP_KEEP_Q16 = 18'sd64225;
  localparam logic signed [MB_W-1:0] COMP_ACC_Q16  = 18'sd1311;
  localparam logic signed [MB_W-1:0] SMOOTH_W_Q16  = 18'sd9830;

  localparam logic [2:0] REG_ACC_BIAS_X  = 3'd0;
  localparam logic [2:0] REG_ACC_BIAS_Y  = 3'd1;
  localparam logic [2:0] REG_ACC_BIAS_Z  = 3'd2;
  localparam logic [2:0] REG_RATE_BIAS_X = 3'd3;
  localparam logic [2:0] REG_RATE_BIAS_Y = 3'd4;
  localparam logic [2:0] REG_MOTION_THR  = 3'd5;
  localparam logic [2:0] REG_OFFSET_LIM  = 3'd6;

  localparam logic [1:0] CLS_CRUISE = 2'd0;
  localparam logic [1:0] CLS_ACCEL  = 2'd1;
  localparam logic [1:0] CLS_BRAKE  = 2'd2;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_req_t;

  typedef struct packed {
    logic go;
    logic accum;
  } mac_req_t;

  function automatic logic signed [ANG_W-1:0] atan_q20(input logic [ITER_W-1:0] idx);
    logic signed [ANG_W-1:0] v;
    unique case (idx)
      5'd0:    v = 32'sd823550;
      5'd1:    v = 32'sd486170;
      5'd2:    v = 32'sd256879;
      5'd3:    v = 32'sd130396;
      5'd4:    v = 32'sd65451;
      5'd5:    v = 32'sd32757;
      5'd6:    v = 32'sd16383;
      5'd7:    v = 32'sd8192;
      5'd8:    v = 32'sd4096;
      5'd9:    v = 32'sd2048;
      5'd10:   v = 32'sd1024;
      5'd11:   v = 32'sd512;
      5'd12:   v = 32'sd256;
      5'd13:   v = 32'sd128;
      5'd14:   v = 32'sd64;
      5'd15:   v = 32'sd32;
      5'd16:   v = 32'sd16;
      5'd17:   v = 32'sd8;
      5'd18:   v = 32'sd4;
      5'd19:   v = 32'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // round half up, then arithmetic shift
  function automatic logic signed [MACC_W-1:0] rnd(input logic signed [MACC_W-1:0] v,
                                                   input int n);
    logic signed [MACC_W-1:0] h;
    h = '0;
    h[n-1] = 1'b1;
    return (v + h) >>> n;
  endfunction

  function automatic logic signed [ACCEL_W-1:0] sat_acc(input logic signed [31:0] v);
    logic signed [ACCEL_W-1:0] r;
    if (v > ACC_MAX) begin
      r = ACCEL_W'(ACC_MAX);
    end else if (v < ACC_MIN) begin
      r = ACCEL_W'(ACC_MIN);
    end else begin
      r = v[ACCEL_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    logic signed [15:0] r;
    if (v[16] != v[15]) begin
      r = v[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/imu_motion_cue_filter_unit.sv -----
// ----------------------------------------------------------------------------
// imu_motion_cue_filter_unit
// Pitch/roll complementary filter with longitudinal motion cue output.
//
//   word      handshake           payload
//   in_*      in_valid/in_ready   accel x/y/z, rate x/y, elapsed_ms
//   out_*     out_valid/out_ready class, offset, long. accel, pitch, roll
//   cfg_*     cfg_we              cfg_idx, cfg_wdata
//
// From one input accept to the next the sequencer runs three CORDIC passes
// (start, 20 steps, done), a 9-step angle reduction and 15 products
// through the single MAC with their update steps. out_valid rises when
// the finished word is loaded from the last step into the output register.
// in_ready is high only while the sequencer is idle; a finished word sits
// in the output register while the next input word is taken, and the
// sequencer holds in its last step while that register is still full.
// Synchronous active-low reset clears filter state and loads register
// defaults; no clearing pass.
// ----------------------------------------------------------------------------
module imu_motion_cue_filter_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_accel_x,
  input  logic signed [15:0] in_accel_y,
  input  logic signed [15:0] in_accel_z,
  input  logic signed [15:0] in_rate_x,
  input  logic signed [15:0] in_rate_y,
  input  logic [15:0]        in_elapsed_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_motion_class,
  output logic signed [13:0] out_visual_offset,
  output logic signed [16:0] out_longitudinal_accel,
  output logic signed [31:0] out_pitch_out,
  output logic signed [31:0] out_roll_out,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [15:0]        cfg_wdata
);

  localparam int SW  = imcf_pkg::SACC_W;
  localparam int AW  = imcf_pkg::ACCEL_W;
  localparam int MW  = imcf_pkg::MACC_W;

  typedef enum logic [23:0] {
    S_IDLE    = 24'h000001,
    S_LPF_MUL = 24'h000002,
    S_LPF_UPD = 24'h000004,
    S_VEC1    = 24'h000008,
    S_VEC1_W  = 24'h000010,
    S_MAG_MUL = 24'h000020,
    S_MAG_UPD = 24'h000040,
    S_VEC2    = 24'h000080,
    S_VEC2_W  = 24'h000100,
    S_GY_MUL1 = 24'h000200,
    S_GY_MUL2 = 24'h000400,
    S_GY_RND  = 24'h000800,
    S_CP_MUL1 = 24'h001000,
    S_CP_MUL2 = 24'h002000,
    S_CP_UPD  = 24'h004000,
    S_RED     = 24'h008000,
    S_ROT     = 24'h010000,
    S_ROT_W   = 24'h020000,
    S_AL_MUL1 = 24'h040000,
    S_AL_MUL2 = 24'h080000,
    S_AL_UPD  = 24'h100000,
    S_OF_MUL  = 24'h200000,
    S_OF_UPD  = 24'h400000,
    S_OUT     = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] bias_ax_r, bias_ay_r, bias_az_r, bias_rx_r, bias_ry_r;
  logic [14:0]        thr_r;
  logic [4:0]         lim_r;

  logic signed [SW-1:0] sacc_r [3];
  logic signed [31:0]   pitch_r, roll_r;
  logic signed [15:0]   offs_r;

  logic signed [AW-1:0] acc_in_r [3];
  logic signed [15:0]   rx_r, ry_r;
  logic [5:0]           ms_r;
  logic [1:0]           ax_idx_r;
  logic                 axis_r;

  logic signed [31:0]   grav_roll_r, grav_pitch_r;
  logic signed [imcf_pkg::CD_W-1:0] mag_r;
  logic signed [23:0]   d_r;
  logic [imcf_pkg::RED_W-1:0] red_r;
  logic                 red_neg_r;
  logic [3:0]           k_r;
  logic                 rot_neg_r;
  logic signed [17:0]   c16_r, s16_r;
  logic signed [16:0]   along_r;
  logic [1:0]           cls_r;

  logic               out_valid_r;
  logic [1:0]         out_cls_r;
  logic signed [13:0] out_offs_r;
  logic signed [16:0] out_along_r;
  logic signed [31:0] out_pitch_r, out_roll_r;

  // shared units
  imcf_pkg::mac_req_t                   mac_req;
  logic signed [imcf_pkg::MA_W-1:0]     mac_a;
  logic signed [imcf_pkg::MB_W-1:0]     mac_b;
  logic signed [MW-1:0]                 mac_acc;

  imcf_pkg::cordic_req_t                cd_req;
  logic signed [imcf_pkg::CD_W-1:0]     cd_x, cd_y, cd_xo, cd_yo;
  logic signed [imcf_pkg::ANG_W-1:0]    cd_z, cd_zo;
  logic                                 cd_done;

  imcf_mac u_mac (
    .clk  (clk),
    .req  (mac_req),
    .op_a (mac_a),
    .op_b (mac_b),
    .acc  (mac_acc)
  );

  imcf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cd_req),
    .x_in  (cd_x),
    .y_in  (cd_y),
    .z_in  (cd_z),
    .done  (cd_done),
    .x_out (cd_xo),
    .y_out (cd_yo),
    .z_out (cd_zo)
  );

  // datapath helpers
  logic signed [SW-1:0]   a256;
  logic signed [SW:0]     lpf_diff;
  logic signed [MW-1:0]   r16, r19, r24;
  logic signed [31:0]     ang_sel, acc_ang_sel, ang_sat;
  logic signed [16:0]     rate_sel;
  logic signed [16:0]     along_sat;
  logic signed [21:0]     of_t;
  logic signed [17:0]     of_new, of_lim, of_clamp;
  logic [imcf_pkg::RED_W-1:0] red_sub;
  logic signed [31:0]     zr, z1, z2;
  logic                   fneg;
  logic signed [imcf_pkg::CD_W:0] xn, yn;

  assign a256     = $signed({acc_in_r[ax_idx_r], 8'h00});
  assign lpf_diff = (SW+1)'(a256) - (SW+1)'(sacc_r[ax_idx_r]);
  assign r16      = imcf_pkg::rnd(mac_acc, 16);
  assign r19      = imcf_pkg::rnd(mac_acc, 19);
  assign r24      = imcf_pkg::rnd(mac_acc, 24);
  assign ang_sel     = axis_r ? roll_r : pitch_r;
  assign acc_ang_sel = axis_r ? grav_roll_r : grav_pitch_r;
  assign rate_sel    = axis_r ? 17'(rx_r) : 17'(ry_r);

  assign ang_sat = (r16[MW-1:31] != {(MW-31){r16[MW-1]}}) ?
                   (r16[MW-1] ? 32'sh80000000 : 32'sh7FFFFFFF) : r16[31:0];
  assign along_sat = (r24[MW-1:16] != {(MW-16){r24[MW-1]}}) ?
                     (r24[MW-1] ? 17'sh10000 : 17'sh0FFFF) : r24[16:0];

  assign of_t = -((22'(along_r) <<< 2) + 22'(along_r)) - (22'(offs_r) <<< 3);
  assign of_new = 18'(offs_r) + r19[17:0];
  assign of_lim = $signed({5'b0, lim_r, 8'h00});
  always_comb begin
    if (of_new > of_lim) begin
      of_clamp = of_lim;
    end else if (of_new < -of_lim) begin
      of_clamp = -of_lim;
    end else begin
      of_clamp = of_new;
    end
  end

  assign red_sub = imcf_pkg::RED_W'(imcf_pkg::TWO_PI_Q20) << k_r;

  always_comb begin
    zr = red_neg_r ? -$signed(red_r[31:0]) : $signed(red_r[31:0]);
    if (zr > imcf_pkg::PI_Q20) begin
      z1 = zr - imcf_pkg::TWO_PI_Q20;
    end else if (zr < -imcf_pkg::PI_Q20) begin
      z1 = zr + imcf_pkg::TWO_PI_Q20;
    end else begin
      z1 = zr;
    end
    fneg = 1'b0;
    z2   = z1;
    if (z1 > imcf_pkg::HALF_PI_Q20) begin
      z2   = z1 - imcf_pkg::PI_Q20;
      fneg = 1'b1;
    end else if (z1 < -imcf_pkg::HALF_PI_Q20) begin
      z2   = z1 + imcf_pkg::PI_Q20;
      fneg = 1'b1;
    end
  end

  assign xn   = rot_neg_r ? -(imcf_pkg::CD_W+1)'(cd_xo) : (imcf_pkg::CD_W+1)'(cd_xo);
  assign yn   = rot_neg_r ? -(imcf_pkg::CD_W+1)'(cd_yo) : (imcf_pkg::CD_W+1)'(cd_yo);

  // unit requests and operand muxes
  always_comb begin
    mac_req = '0;
    mac_a   = '0;
    mac_b   = '0;
    cd_req  = '0;
    cd_x    = '0;
    cd_y    = '0;
    cd_z    = '0;
    unique case (state_r)
      S_LPF_MUL: begin
        mac_req.go = 1'b1;
        mac_a = imcf_pkg::MA_W'(lpf_diff);
        mac_b = imcf_pkg::LPF_W_Q16;
      end
      S_VEC1: begin
        cd_req.start    = 1'b1;
        cd_req.vec_mode = 1'b1;
        cd_x = imcf_pkg::CD_W'(sacc_r[2]);
        cd_y = imcf_pkg::CD_W'(sacc_r[1]);
      end
      S_MAG_MUL: begin
        mac_req.go = 1'b1;
        mac_a = cd_xo;
        mac_b = imcf_pkg::INV_GAIN_Q16;
      end
      S_VEC2: begin
        cd_req.start    = 1'b1;
        cd_req.vec_mode = 1'b1;
        cd_x = mag_r;
        cd_y = -imcf_pkg::CD_W'(sacc_r[0]);
      end
      S_GY_MUL1: begin
        mac_req.go = 1'b1;
        mac_a = imcf_pkg::MA_W'(rate_sel);
        mac_b = $signed({12'b0, ms_r});
      end
      S_GY_MUL2: begin
        mac_req.go = 1'b1;
        mac_a = mac_acc[imcf_pkg::MA_W-1:0];
        mac_b = imcf_pkg::GYRO_GAIN_Q16;
      end
      S_CP_MUL1: begin
        mac_req.go = 1'b1;
        mac_a = imcf_pkg::MA_W'(ang_sel) + imcf_pkg::MA_W'(d_r);
        mac_b = imcf_pkg::COMP_KEEP_Q16;
      end
      S_CP_MUL2: begin
        mac_req.go    = 1'b1;
        mac_req.accum = 1'b1;
        mac_a = imcf_pkg::MA_W'(acc_ang_sel);
        mac_b = imcf_pkg::COMP_ACC_Q16;
      end
      S_ROT: begin
        cd_req.start = 1'b1;
        cd_x = imcf_pkg::INV_GAIN_Q30;
        cd_y = '0;
        cd_z = z2;
      end
      S_AL_MUL1: begin
        mac_req.go = 1'b1;
        mac_a = imcf_pkg::MA_W'(sacc_r[0]);
        mac_b = c16_r;
      end
      S_AL_MUL2: begin
        mac_req.go    = 1'b1;
        mac_req.accum = 1'b1;
        mac_a = imcf_pkg::MA_W'(sacc_r[2]);
        mac_b = s16_r;
      end
      S_OF_MUL: begin
        mac_req.go = 1'b1;
        mac_a = imcf_pkg::MA_W'(of_t);
        mac_b = imcf_pkg::SMOOTH_W_Q16;
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_LPF_MUL;
      S_LPF_MUL: state_nxt = S_LPF_UPD;
      S_LPF_UPD: state_nxt = (ax_idx_r == 2'd2) ? S_VEC1 : S_LPF_MUL;
      S_VEC1:    state_nxt = S_VEC1_W;
      S_VEC1_W:  if (cd_done) state_nxt = S_MAG_MUL;
      S_MAG_MUL: state_nxt = S_MAG_UPD;
      S_MAG_UPD: state_nxt = S_VEC2;
      S_VEC2:    state_nxt = S_VEC2_W;
      S_VEC2_W:  if (cd_done) state_nxt = S_GY_MUL1;
      S_GY_MUL1: state_nxt = S_GY_MUL2;
      S_GY_MUL2: state_nxt = S_GY_RND;
      S_GY_RND:  state_nxt = S_CP_MUL1;
      S_CP_MUL1: state_nxt = S_CP_MUL2;
      S_CP_MUL2: state_nxt = S_CP_UPD;
      S_CP_UPD:  state_nxt = axis_r ? S_RED : S_GY_MUL1;
      S_RED:     if (k_r == 4'd0) state_nxt = S_ROT;
      S_ROT:     state_nxt = S_ROT_W;
      S_ROT_W:   if (cd_done) state_nxt = S_AL_MUL1;
      S_AL_MUL1: state_nxt = S_AL_MUL2;
      S_AL_MUL2: state_nxt = S_AL_UPD;
      S_AL_UPD:  state_nxt = S_OF_MUL;
      S_OF_MUL:  state_nxt = S_OF_UPD;
      S_OF_UPD:  state_nxt = S_OUT;
      S_OUT:     if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  assign in_ready = (state_r == S_IDLE);

  // control state, configuration and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      bias_ax_r   <= '0;
      bias_ay_r   <= '0;
      bias_az_r   <= '0;
      bias_rx_r   <= '0;
      bias_ry_r   <= '0;
      thr_r       <= 15'd819;
      lim_r       <= 5'd12;
      sacc_r[0]   <= '0;
      sacc_r[1]   <= '0;
      sacc_r[2]   <= '0;
      pitch_r     <= '0;
      roll_r      <= '0;
      offs_r      <= '0;
      ax_idx_r    <= '0;
      axis_r      <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          imcf_pkg::REG_ACC_BIAS_X:  bias_ax_r <= cfg_wdata;
          imcf_pkg::REG_ACC_BIAS_Y:  bias_ay_r <= cfg_wdata;
          imcf_pkg::REG_ACC_BIAS_Z:  bias_az_r <= cfg_wdata;
          imcf_pkg::REG_RATE_BIAS_X: bias_rx_r <= cfg_wdata;
          imcf_pkg::REG_RATE_BIAS_Y: bias_ry_r <= cfg_wdata;
          imcf_pkg::REG_MOTION_THR:  thr_r     <= cfg_wdata[14:0];
          imcf_pkg::REG_OFFSET_LIM:  lim_r     <= cfg_wdata[4:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_OUT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          ax_idx_r <= '0;
          axis_r   <= 1'b0;
        end
        S_LPF_UPD: begin
          sacc_r[ax_idx_r] <= sacc_r[ax_idx_r] + r16[SW-1:0];
          ax_idx_r <= ax_idx_r + 2'd1;
        end
        S_CP_UPD: begin
          if (axis_r) begin
            roll_r <= ang_sat;
            k_r    <= 4'd8;
          end else begin
            pitch_r <= ang_sat;
            axis_r  <= 1'b1;
          end
        end
        S_RED: begin
          if (k_r != 4'd0) begin
            k_r <= k_r - 4'd1;
          end
        end
        S_OF_UPD: offs_r <= of_clamp[15:0];
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_in_r[0] <= imcf_pkg::sat_acc(32'(in_accel_x) - 32'(bias_ax_r));
          acc_in_r[1] <= imcf_pkg::sat_acc(32'(in_accel_y) - 32'(bias_ay_r));
          acc_in_r[2] <= imcf_pkg::sat_acc(32'(in_accel_z) - 32'(bias_az_r));
          rx_r <= imcf_pkg::sat16(17'(in_rate_x) - 17'(bias_rx_r));
          ry_r <= imcf_pkg::sat16(17'(in_rate_y) - 17'(bias_ry_r));
          ms_r <= (in_elapsed_ms > 16'd50) ? 6'd10 : in_elapsed_ms[5:0];
        end
      end
      S_VEC1_W:  if (cd_done) grav_roll_r <= cd_zo;
      S_MAG_UPD: mag_r <= r16[imcf_pkg::CD_W-1:0];
      S_VEC2_W:  if (cd_done) grav_pitch_r <= cd_zo;
      S_GY_RND:  d_r <= r16[23:0];
      S_CP_UPD: begin
        if (axis_r) begin
          red_r     <= pitch_r[31] ? -imcf_pkg::RED_W'(pitch_r) : imcf_pkg::RED_W'(pitch_r);
          red_neg_r <= pitch_r[31];
        end
      end
      S_RED: begin
        if (red_r >= red_sub) begin
          red_r <= red_r - red_sub;
        end
      end
      S_ROT: rot_neg_r <= fneg;
      S_ROT_W: begin
        if (cd_done) begin
          c16_r <= 18'((xn + (imcf_pkg::CD_W+1)'(8192)) >>> 14);
          s16_r <= 18'((yn + (imcf_pkg::CD_W+1)'(8192)) >>> 14);
        end
      end
      S_AL_UPD: along_r <= along_sat;
      S_OF_UPD: begin
        if (along_r > $signed({2'b0, thr_r})) begin
          cls_r <= imcf_pkg::CLS_ACCEL;
        end else if (along_r < -$signed({2'b0, thr_r})) begin
          cls_r <= imcf_pkg::CLS_BRAKE;
        end else begin
          cls_r <= imcf_pkg::CLS_CRUISE;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_cls_r   <= cls_r;
          out_offs_r  <= offs_r[13:0];
          out_along_r <= along_r;
          out_pitch_r <= pitch_r;
          out_roll_r  <= roll_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid              = out_valid_r;
  assign out_motion_class       = out_cls_r;
  assign out_visual_offset      = out_offs_r;
  assign out_longitudinal_accel = out_along_r;
  assign out_pitch_out          = out_pitch_r;
  assign out_roll_out           = out_roll_r;

endmodule

// ----- rtl/imcf_mac.sv -----
// ----------------------------------------------------------------------------
// imcf_mac
// Shared signed multiply-accumulate unit, one product per cycle.
// ----------------------------------------------------------------------------
module imcf_mac (
  input  logic                                 clk,
  input  imcf_pkg::mac_req_t                   req,
  input  logic signed [imcf_pkg::MA_W-1:0]     op_a,
  input  logic signed [imcf_pkg::MB_W-1:0]     op_b,
  output logic signed [imcf_pkg::MACC_W-1:0]   acc
);

  logic signed [imcf_pkg::MA_W+imcf_pkg::MB_W-1:0] prod;
  logic signed [imcf_pkg::MACC_W-1:0]              acc_r;

  assign prod = op_a * op_b;
  assign acc  = acc_r;

  always_ff @(posedge clk) begin
    if (req.go) begin
      acc_r <= (req.accum ? acc_r : '0) + imcf_pkg::MACC_W'(prod);
    end
  end

endmodule

// ----- rtl/imcf_cordic.sv -----
// ----------------------------------------------------------------------------
// imcf_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module imcf_cordic (
  input  logic                                clk,
  input  logic                                rst_n,
  input  imcf_pkg::cordic_req_t               req,
  input  logic signed [imcf_pkg::CD_W-1:0]    x_in,
  input  logic signed [imcf_pkg::CD_W-1:0]    y_in,
  input  logic signed [imcf_pkg::ANG_W-1:0]   z_in,
  output logic                                done,
  output logic signed [imcf_pkg::CD_W-1:0]    x_out,
  output logic signed [imcf_pkg::CD_W-1:0]    y_out,
  output logic signed [imcf_pkg::ANG_W-1:0]   z_out
);

  logic signed [imcf_pkg::CD_W-1:0]  x_r, y_r, xs, ys;
  logic signed [imcf_pkg::ANG_W-1:0] z_r, at;
  logic [imcf_pkg::ITER_W-1:0]       cnt_r;
  logic                              busy_r, done_r, vec_r, zero_r, plus;

  assign xs   = x_r >>> cnt_r;
  assign ys   = y_r >>> cnt_r;
  assign at   = imcf_pkg::atan_q20(cnt_r);
  assign plus = vec_r ? !y_r[imcf_pkg::CD_W-1] : z_r[imcf_pkg::ANG_W-1];

  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = zero_r ? '0 : z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      if (req.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == imcf_pkg::ITER_W'(imcf_pkg::CORDIC_ITERS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          done_r <= 1'b0;
          cnt_r  <= cnt_r + 1'b1;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      vec_r  <= req.vec_mode;
      zero_r <= req.vec_mode && (x_in == '0) && (y_in == '0);
      if (req.vec_mode && x_in[imcf_pkg::CD_W-1]) begin
        x_r <= -x_in;
        y_r <= -y_in;
        z_r <= y_in[imcf_pkg::CD_W-1] ? -imcf_pkg::PI_Q20 : imcf_pkg::PI_Q20;
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= req.vec_mode ? '0 : z_in;
      end
    end else if (busy_r) begin
      if (plus) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end
    end
  end

endmodule

// ----- sim/tb_imu_motion_cue_filter_unit.sv -----
// ----------------------------------------------------------------------------
// tb_imu_motion_cue_filter_unit
// Self-checking bench for the IMU motion cue filter. Samples go in on a
// valid/ready channel. A cycle-free predictor tracks the filter state and the
// registers, and every output word is checked field by field against it.
// There is a directed set first, then three random phases with different
// register settings and with stalls weighted to the output side, to the input
// side, or none at all.
// ----------------------------------------------------------------------------
module tb_imu_motion_cue_filter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic signed [15:0] ax, ay, az, rx, ry;
    logic [15:0]        ms;
  } imu_sample_t;

  typedef struct {
    logic [1:0]         cls;
    logic signed [13:0] offset;
    logic signed [16:0] along;
    logic signed [31:0] pitch, roll;
  } motion_cue_t;

  class cue_scoreboard;
    longint bias_acc[3], bias_rate[2], thr, lim;
    longint sm_acc[3], pitch, roll, offv;
    longint atan_tab[20];
    motion_cue_t expected_cues[$];
    int mismatches, checked;

    function new();
      for (int i = 0; i < 20; i++)
        atan_tab[i] = longint'(imcf_pkg::atan_q20(imcf_pkg::ITER_W'(i)));
      for (int i = 0; i < 3; i++) begin
        bias_acc[i] = 0;
        sm_acc[i] = 0;
      end
      bias_rate[0] = 0;
      bias_rate[1] = 0;
      thr = 819;
      lim = 12;
      pitch = 0;
      roll = 0;
      offv = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function longint round_sh(longint v, int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function longint sat_to(longint v, int w);
      longint hi, lo;
      hi = (64'sd1 <<< (w - 1)) - 1;
      lo = -(64'sd1 <<< (w - 1));
      return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        imcf_pkg::REG_ACC_BIAS_X:  bias_acc[0] = longint'(signed'(val));
        imcf_pkg::REG_ACC_BIAS_Y:  bias_acc[1] = longint'(signed'(val));
        imcf_pkg::REG_ACC_BIAS_Z:  bias_acc[2] = longint'(signed'(val));
        imcf_pkg::REG_RATE_BIAS_X: bias_rate[0] = longint'(signed'(val));
        imcf_pkg::REG_RATE_BIAS_Y: bias_rate[1] = longint'(signed'(val));
        imcf_pkg::REG_MOTION_THR:  thr = longint'(val[14:0]);
        imcf_pkg::REG_OFFSET_LIM:  lim = longint'(val[4:0]);
        default: ;
      endcase
    endfunction

    function void vector_angle(longint xi, longint yi, output longint ang,
                               output longint mag);
      longint x, y, z, xs, ys;
      x = xi;
      y = yi;
      z = 0;
      if (x == 0 && y == 0) begin
        ang = 0;
        mag = 0;
        return;
      end
      if (x < 0) begin
        z = (y >= 0) ? longint'(imcf_pkg::PI_Q20) : -longint'(imcf_pkg::PI_Q20);
        x = -x;
        y = -y;
      end
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += atan_tab[i];
        end else begin
          x -= ys; y += xs; z -= atan_tab[i];
        end
      end
      ang = z;
      mag = round_sh(x * longint'(imcf_pkg::INV_GAIN_Q16), 16);
    endfunction

    function void angle_sincos(longint ang, output longint c16, output longint s16);
      longint z, x, y, xs, ys;
      bit neg;
      z = ang % longint'(imcf_pkg::TWO_PI_Q20);
      x = longint'(imcf_pkg::INV_GAIN_Q30);
      y = 0;
      neg = 0;
      if (z > longint'(imcf_pkg::PI_Q20)) z -= longint'(imcf_pkg::TWO_PI_Q20);
      if (z < -longint'(imcf_pkg::PI_Q20)) z += longint'(imcf_pkg::TWO_PI_Q20);
      if (z > longint'(imcf_pkg::HALF_PI_Q20)) begin
        z -= longint'(imcf_pkg::PI_Q20); neg = 1;
      end else if (z < -longint'(imcf_pkg::HALF_PI_Q20)) begin
        z += longint'(imcf_pkg::PI_Q20); neg = 1;
      end
      for (int i = 0; i < 20; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      if (neg) begin
        x = -x; y = -y;
      end
      c16 = round_sh(x, 14);
      s16 = round_sh(y, 14);
    endfunction

    function void take_sample(imu_sample_t s);
      longint raw[3], a, rx, ry, ms, d, grav_roll, grav_pitch, mag, unused, c16, s16, al;
      motion_cue_t e;
      raw[0] = longint'(s.ax);
      raw[1] = longint'(s.ay);
      raw[2] = longint'(s.az);
      for (int i = 0; i < 3; i++) begin
        a = sat_to(raw[i] - bias_acc[i], imcf_pkg::ACCEL_W);
        sm_acc[i] += round_sh((a * 256 - sm_acc[i]) * longint'(imcf_pkg::LPF_W_Q16), 16);
      end
      rx = sat_to(longint'(s.rx) - bias_rate[0], 16);
      ry = sat_to(longint'(s.ry) - bias_rate[1], 16);
      ms = longint'(s.ms);
      if (ms > 50) ms = 10;
      vector_angle(sm_acc[2], sm_acc[1], grav_roll, mag);
      vector_angle(mag, -sm_acc[0], grav_pitch, unused);
      d = round_sh(ry * ms * longint'(imcf_pkg::GYRO_GAIN_Q16), 16);
      pitch = sat_to(round_sh((pitch + d) * longint'(imcf_pkg::COMP_KEEP_Q16) +
                              grav_pitch * longint'(imcf_pkg::COMP_ACC_Q16), 16), 32);
      d = round_sh(rx * ms * longint'(imcf_pkg::GYRO_GAIN_Q16), 16);
      roll = sat_to(round_sh((roll + d) * longint'(imcf_pkg::COMP_KEEP_Q16) +
                             grav_roll * longint'(imcf_pkg::COMP_ACC_Q16), 16), 32);
      angle_sincos(pitch, c16, s16);
      al = sat_to(round_sh(sm_acc[0] * c16 + sm_acc[2] * s16, 24), 17);
      if (al > thr) e.cls = imcf_pkg::CLS_ACCEL;
      else if (al < -thr) e.cls = imcf_pkg::CLS_BRAKE;
      else e.cls = imcf_pkg::CLS_CRUISE;
      offv += round_sh((-5 * al - 8 * offv) * longint'(imcf_pkg::SMOOTH_W_Q16), 19);
      if (offv > lim * 256) offv = lim * 256;
      else if (offv < -lim * 256) offv = -lim * 256;
      e.offset = offv[13:0];
      e.along = al[16:0];
      e.pitch = pitch[31:0];
      e.roll = roll[31:0];
      expected_cues.push_back(e);
    endfunction

    function void check_cue(motion_cue_t got);
      motion_cue_t e;
      checked++;
      if (expected_cues.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected output word: cls=%0d off=%0d long=%0d pitch=%0d roll=%0d",
                   got.cls, got.offset, got.along, got.pitch, got.roll);
        return;
      end
      e = expected_cues.pop_front();
      if (got.cls !== e.cls || got.offset !== e.offset || got.along !== e.along ||
          got.pitch !== e.pitch || got.roll !== e.roll) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch word %0d: exp cls=%0d off=%0d long=%0d pitch=%0d roll=%0d",
                   checked, e.cls, e.offset, e.along, e.pitch, e.roll);
          $display("                got cls=%0d off=%0d long=%0d pitch=%0d roll=%0d",
                   got.cls, got.offset, got.along, got.pitch, got.roll);
        end
      end
    endfunction
  endclass

  logic               clk, rst_n;
  logic               in_valid, in_ready, out_valid, out_ready;
  logic signed [15:0] in_accel_x, in_accel_y, in_accel_z, in_rate_x, in_rate_y;
  logic [15:0]        in_elapsed_ms;
  logic [1:0]         out_motion_class;
  logic signed [13:0] out_visual_offset;
  logic signed [16:0] out_longitudinal_accel;
  logic signed [31:0] out_pitch_out, out_roll_out;
  logic               cfg_we;
  logic [2:0]         cfg_idx;
  logic [15:0]        cfg_wdata;

  cue_scoreboard sb;
  int tx_idle_pct, rx_idle_pct, samples_sent;

  imu_motion_cue_filter_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("tb_imu_motion_cue_filter_unit: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    motion_cue_t got;
    if (rst_n) begin
      if (cfg_we) sb.write_reg(cfg_idx, cfg_wdata);
      if (in_valid && in_ready)
        sb.take_sample('{in_accel_x, in_accel_y, in_accel_z, in_rate_x, in_rate_y,
                         in_elapsed_ms});
      if (out_valid && out_ready) begin
        got.cls = out_motion_class;
        got.offset = out_visual_offset;
        got.along = out_longitudinal_accel;
        got.pitch = out_pitch_out;
        got.roll = out_roll_out;
        sb.check_cue(got);
      end
    end
  end

  always @(negedge clk) out_ready = ($urandom_range(99) >= rx_idle_pct);

  task automatic send_sample(imu_sample_t s);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_accel_x = s.ax;
    in_accel_y = s.ay;
    in_accel_z = s.az;
    in_rate_x = s.rx;
    in_rate_y = s.ry;
    in_elapsed_ms = s.ms;
    do @(posedge clk); while (!in_ready);
    samples_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain_outputs();
    in_valid = 1'b0;
    while (sb.expected_cues.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_edge();
    case ($urandom_range(3))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t make_sample();
    imu_sample_t s;
    int mode;
    mode = $urandom_range(9);
    if (mode <= 6) begin
      s.ax = 16'($signed($urandom_range(6000)) - 3000);
      s.ay = 16'($signed($urandom_range(6000)) - 3000);
      s.az = 16'($signed($urandom_range(4000)) + 6192);
      if ($urandom_range(7) == 0) s.az = -s.az;
      s.rx = 16'($signed($urandom_range(1600)) - 800);
      s.ry = 16'($signed($urandom_range(1600)) - 800);
      s.ms = 16'($urandom_range(15, 5));
    end else if (mode == 7) begin
      s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
      s.rx = 16'($urandom); s.ry = 16'($urandom);
      s.ms = 16'($urandom);
    end else begin
      s.ax = pick_edge(); s.ay = pick_edge(); s.az = pick_edge();
      s.rx = pick_edge(); s.ry = pick_edge();
      s.ms = 16'($urandom_range(60));
    end
    if (mode == 9) begin
      case ($urandom_range(3))
        0: s.ms = 16'd0;
        1: s.ms = 16'd50;
        2: s.ms = 16'd51;
        default: s.ms = 16'hFFFF;
      endcase
    end
    return s;
  endfunction

  task automatic random_phase(int n, int tx_pct, int rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (n) send_sample(make_sample());
    drain_outputs();
  endtask

  initial begin
    sb = new();
    samples_sent = 0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_accel_x = '0; in_accel_y = '0; in_accel_z = '0;
    in_rate_x = '0; in_rate_y = '0; in_elapsed_ms = '0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed set, reset register values
    tx_idle_pct = 13;
    rx_idle_pct = 85;
    send_sample('{0, 0, 0, 0, 0, 10});
    send_sample('{0, 0, 0, 0, 0, 0});
    send_sample('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'hFFFF});
    send_sample('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 50});
    send_sample('{0, 16'sh1000, -16'sh2000, 0, 0, 51});
    send_sample('{0, -16'sh1000, -16'sh2000, 0, 0, 0});
    send_sample('{0, -16'sh1000, -16'sh2000, 0, 0, 0});
    send_sample('{16'sh2000, 0, 0, 0, 0, 20});
    send_sample('{-16'sh2000, 0, 16'sh2000, 0, 0, 20});
    repeat (8) send_sample('{16'sh0800, 0, 16'sh2000, 16'sh7FFF, 16'sh7FFF, 50});
    repeat (4) send_sample('{-16'sh0800, 0, 16'sh2000, 16'sh8000, 16'sh8000, 50});
    drain_outputs();

    write_reg(imcf_pkg::REG_ACC_BIAS_X, 16'd0);
    write_reg(imcf_pkg::REG_ACC_BIAS_Y, 16'd0);
    write_reg(imcf_pkg::REG_ACC_BIAS_Z, 16'd0);
    write_reg(imcf_pkg::REG_RATE_BIAS_X, 16'd0);
    write_reg(imcf_pkg::REG_RATE_BIAS_Y, 16'd0);
    write_reg(imcf_pkg::REG_MOTION_THR, 16'd0);
    write_reg(imcf_pkg::REG_OFFSET_LIM, 16'd31);
    write_reg(REG_UNUSED, 16'hFFFF);
    random_phase(160, 13, 85);

    write_reg(imcf_pkg::REG_ACC_BIAS_X, 16'h8000);
    write_reg(imcf_pkg::REG_ACC_BIAS_Y, 16'h7FFF);
    write_reg(imcf_pkg::REG_ACC_BIAS_Z, 16'h8000);
    write_reg(imcf_pkg::REG_RATE_BIAS_X, 16'h7FFF);
    write_reg(imcf_pkg::REG_RATE_BIAS_Y, 16'h8000);
    write_reg(imcf_pkg::REG_MOTION_THR, 16'h7FFF);
    write_reg(imcf_pkg::REG_OFFSET_LIM, 16'd0);
    random_phase(160, 85, 13);

    write_reg(imcf_pkg::REG_ACC_BIAS_X, 16'($signed($urandom_range(800)) - 400));
    write_reg(imcf_pkg::REG_ACC_BIAS_Y, 16'($signed($urandom_range(800)) - 400));
    write_reg(imcf_pkg::REG_ACC_BIAS_Z, 16'($signed($urandom_range(800)) - 400));
    write_reg(imcf_pkg::REG_RATE_BIAS_X, 16'($signed($urandom_range(100)) - 50));
    write_reg(imcf_pkg::REG_RATE_BIAS_Y, 16'($signed($urandom_range(100)) - 50));
    write_reg(imcf_pkg::REG_MOTION_THR, 16'($urandom_range(2000)));
    write_reg(imcf_pkg::REG_OFFSET_LIM, 16'($urandom_range(31, 1)));
    random_phase(160, 0, 0);

    if (sb.expected_cues.size() != 0) sb.mismatches += sb.expected_cues.size();
    $display("%0d samples sent, %0d output words checked, %0d mismatches", samples_sent,
             sb.checked, sb.mismatches);
    $display("four register settings incl. extremes; stalls on input, output, and none");
    if (sb.mismatches == 0) begin
      $display("tb_imu_motion_cue_filter_unit: PASS");
    end else begin
      $display("tb_imu_motion_cue_filter_unit: FAIL");
    end
    $finish;
  end
endmodule
